// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clk edge outside reset.
`define CSF_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("semaphore port check failed");

// Check an implication that must hold in the cycle after the trigger.
`define CSF_ASSERT_NEXT(label, trig, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error("semaphore port check failed one cycle later");

`endif

// ----- rtl/core/csf_pkg.sv -----
// Package with the shared types and constants of the counting semaphore.
`timescale 1ns / 1ps

package csf_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TASK_BITS       = 8;
    localparam int COUNT_BITS      = 16;
    localparam int WAITERS_BITS    = 5;
    localparam int RESULT_BITS     = 5 + TASK_BITS + COUNT_BITS + WAITERS_BITS;
    localparam int RESULT_BYTES_W  = ((RESULT_BITS + 7) / 8) * 8;

    localparam logic REQ_WAIT = 1'b0;
    localparam logic REQ_POST = 1'b1;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } csf_q_ctrl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } csf_q_stat_t;

endpackage

// ----- rtl/core/csf_cell.sv -----
// One slot of the wait queue: load a task from the tail side or take the neighbor's on a pop.
`timescale 1ns / 1ps

module csf_cell
    import csf_pkg::*;
(
    input  logic                 clk,
    input  logic                 shift,
    input  logic                 load,
    input  logic [TASK_BITS-1:0] load_data,
    input  logic [TASK_BITS-1:0] next_data,
    output logic [TASK_BITS-1:0] data
);

    logic [TASK_BITS-1:0] data_reg;
    logic [TASK_BITS-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (load)
        begin
            data_next = load_data;
        end
        else if (shift)
        begin
            data_next = next_data;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ----- rtl/core/csf_queue.sv -----
// Wait queue built as a row of cells with the oldest waiter in cell zero.
`timescale 1ns / 1ps

module csf_queue
    import csf_pkg::*;
#(
    parameter int DEPTH  = QUEUE_DEPTH_DEF,
    parameter int FILL_W = $clog2(DEPTH + 1)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  csf_q_ctrl_t          ctrl,
    input  logic [TASK_BITS-1:0] push_data,
    output logic [TASK_BITS-1:0] head_data,
    output logic [FILL_W-1:0]    fill,
    output csf_q_stat_t          stat
);

    logic [TASK_BITS-1:0] cell_data [DEPTH];
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;

    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            logic [TASK_BITS-1:0] nbr;
            if (gi == DEPTH - 1)
            begin : g_last
                assign nbr = cell_data[gi];
            end
            else
            begin : g_mid
                assign nbr = cell_data[gi + 1];
            end

            csf_cell u_cell (
                .clk       (clk),
                .shift     (ctrl.pop),
                .load      (ctrl.push && (fill_reg == FILL_W'(gi))),
                .load_data (push_data),
                .next_data (nbr),
                .data      (cell_data[gi])
            );
        end
    endgenerate

    always_comb
    begin
        fill_next = fill_reg;
        if (ctrl.clear)
        begin
            fill_next = '0;
        end
        else if (ctrl.push)
        begin
            fill_next = fill_reg + FILL_W'(1);
        end
        else if (ctrl.pop)
        begin
            fill_next = fill_reg - FILL_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    assign head_data  = cell_data[0];
    assign fill       = fill_reg;
    assign stat.empty = (fill_reg == '0);
    assign stat.full  = (fill_reg == FILL_W'(DEPTH));

endmodule

// ----- rtl/core/counting_semaphore_fifo_core.sv -----
// Top level of the counting semaphore with its FIFO of waiting tasks.
//
//   channel  | direction | signals                          | content
//   ---------+-----------+----------------------------------+-------------------------------
//   s_*      | in        | s_tvalid s_tready s_tdata s_tuser | one wait or post request
//   m_*      | out       | m_tvalid m_tready m_tdata        | one result per request
//   cfg_*    | in        | cfg_valid cfg_ready cfg_data     | initial count, reinitializes
//
// For each request, the count and the queue cells update at the accept edge
// and the result sits in the output register from the next cycle on.
// A new beat is accepted every cycle while the output register is empty or being drained.
// rst_n clears the count, the fill count and the output valid flag; cfg_ready is always high.
// Queue cells all shift toward the head together on a post, so a pop does not depend on depth.
`timescale 1ns / 1ps

module counting_semaphore_fifo_core
    import csf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [TASK_BITS-1:0]      s_tdata,  // [7:0] task_id
    input  logic                      s_tuser,  // [0] req_type
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [RESULT_BYTES_W-1:0] m_tdata,  // granted, blocked, rejected, woken_valid,
                                                // woken_task, saturated, count_now,
                                                // waiters_now, zero fill
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [COUNT_BITS-1:0]     cfg_data
);

    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [COUNT_BITS-1:0]   count_reg;
    logic [COUNT_BITS-1:0]   count_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [RESULT_BITS-1:0]  result_reg;
    logic [RESULT_BITS-1:0]  result_next;

    csf_q_ctrl_t             q_ctrl;
    csf_q_stat_t             q_stat;
    logic [TASK_BITS-1:0]    q_head;
    logic [FILL_W-1:0]       q_fill;
    logic [FILL_W-1:0]       fill_after;

    logic                    accept;
    logic                    cfg_write;
    logic                    is_post;
    logic                    granted;
    logic                    blocked;
    logic                    rejected;
    logic                    woken_valid;
    logic [TASK_BITS-1:0]    woken_task;
    logic                    saturated;

    assign s_tready  = !out_valid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign cfg_write = cfg_valid && cfg_ready;
    assign is_post   = (s_tuser == REQ_POST);

    always_comb
    begin
        granted     = 1'b0;
        blocked     = 1'b0;
        rejected    = 1'b0;
        woken_valid = 1'b0;
        woken_task  = '0;
        saturated   = 1'b0;
        count_next  = count_reg;
        q_ctrl      = '0;
        fill_after  = q_fill;

        if (cfg_write)
        begin
            count_next   = cfg_data;
            q_ctrl.clear = 1'b1;
        end
        else if (accept)
        begin
            if (!is_post)
            begin
                if (count_reg != '0)
                begin
                    count_next = count_reg - COUNT_BITS'(1);
                    granted    = 1'b1;
                end
                else if (!q_stat.full)
                begin
                    q_ctrl.push = 1'b1;
                    fill_after  = q_fill + FILL_W'(1);
                    blocked     = 1'b1;
                end
                else
                begin
                    rejected = 1'b1;
                end
            end
            else
            begin
                if (&count_reg)
                begin
                    saturated = 1'b1;
                end
                else
                begin
                    count_next = count_reg + COUNT_BITS'(1);
                end
                if (!q_stat.empty)
                begin
                    q_ctrl.pop  = 1'b1;
                    fill_after  = q_fill - FILL_W'(1);
                    woken_valid = 1'b1;
                    woken_task  = q_head;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        result_next    = result_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
            result_next    = {WAITERS_BITS'(fill_after), count_next, saturated, woken_task,
                              woken_valid, rejected, blocked, granted};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    csf_queue #(
        .DEPTH  (QUEUE_DEPTH),
        .FILL_W (FILL_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (q_ctrl),
        .push_data (s_tdata),
        .head_data (q_head),
        .fill      (q_fill),
        .stat      (q_stat)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(RESULT_BYTES_W - RESULT_BITS){1'b0}}, result_reg};

endmodule

// ----- rtl/core/csf_checker.sv -----
// Port-level checks of the counting semaphore, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module csf_checker
    import csf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    input  logic                      s_tready,
    input  logic                      m_tvalid,
    input  logic                      m_tready,
    input  logic [RESULT_BYTES_W-1:0] m_tdata
);

    localparam int CNT_LO = 5 + TASK_BITS;
    localparam int CNT_HI = CNT_LO + COUNT_BITS - 1;

    logic wait_kind;
    logic post_flags;
    logic count_zero;

    assign wait_kind  = m_tdata[0] || m_tdata[1] || m_tdata[2];
    assign post_flags = m_tdata[3] || m_tdata[4 + TASK_BITS];
    assign count_zero = (m_tdata[CNT_HI:CNT_LO] == '0);

    `CSF_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CSF_ASSERT_NEXT(a_result_follows, s_tvalid && s_tready, m_tvalid)
    `CSF_ASSERT(a_wait_outcome, !m_tvalid || $onehot0(m_tdata[2:0]))
    `CSF_ASSERT(a_wait_no_post_flags, !(m_tvalid && wait_kind) || !post_flags)
    `CSF_ASSERT(a_queued_at_zero, !(m_tvalid && (m_tdata[1] || m_tdata[2])) || count_zero)

endmodule

bind counting_semaphore_fifo_core csf_checker u_csf_checker (.*);
